// ----- hw/rtl/gtm_pkg.sv -----
package gtm_pkg;

	// Parameter defaults
	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int STATE_WIDTH_DEF    = 48;

	// Fixed field widths
	localparam int COEF_W    = 18;
	localparam int MAG_W     = 50;
	localparam int CFG_IDX_W = 2;

	// Limb arithmetic: operands are split into 24-bit limbs, three limbs
	// cover the widest state (64 bits) and the magnitude operands (50 bits)
	localparam int LIMB_W    = 24;
	localparam int NUM_LIMBS = 3;
	localparam int WIDE_W    = NUM_LIMBS * LIMB_W;
	localparam int IDX_W     = 2;
	localparam int POS_W     = 3;
	localparam int MUL_W     = LIMB_W + 1;
	localparam int PROD_W    = 2 * MUL_W;

	// Accumulator holds c*s1 and I^2+Q^2; its width is an even bit count
	// so the square root takes two bits per step
	localparam int ACC_W  = 2 * (MAG_W + 1);
	localparam int REM_W  = MAG_W + 4;
	localparam int STEP_W = 6;

	// Register reset values and indexes
	localparam logic [COEF_W-1:0] COS_RESET = 18'h10000;
	localparam logic [COEF_W-1:0] SIN_RESET = 18'h00000;
	localparam logic [CFG_IDX_W-1:0] CFG_COS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIN = 2'd1;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_MAC,
		DP_REC,
		DP_IVAL,
		DP_QVAL,
		DP_SQRT,
		DP_OUT
	} dp_op_t;

	typedef enum logic [1:0] {
		MS_COS,
		MS_SIN,
		MS_SQ_I,
		MS_SQ_Q
	} mul_sel_t;

	typedef struct packed {
		dp_op_t           op;
		mul_sel_t         msel;
		logic [IDX_W-1:0] ia;
		logic [IDX_W-1:0] ib;
		logic             first;
	} dp_cmd_t;

	typedef struct packed {
		logic big;
	} dp_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REC_MAC,
		ST_REC_DRAIN,
		ST_REC_DONE,
		ST_I_MAC,
		ST_I_DRAIN,
		ST_I_DONE,
		ST_Q_MAC,
		ST_Q_DRAIN,
		ST_Q_DONE,
		ST_SQ_MAC,
		ST_SQ_DRAIN,
		ST_SQRT,
		ST_OUT
	} ctl_state_t;

endpackage

// ----- hw/rtl/gtm_ctrl.sv -----
module gtm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_ready,
	input  gtm_pkg::dp_sts_t  sts,
	output gtm_pkg::dp_cmd_t  cmd
);

	localparam logic [gtm_pkg::IDX_W-1:0] LIMB_LAST =
		gtm_pkg::IDX_W'(gtm_pkg::NUM_LIMBS - 1);
	localparam logic [gtm_pkg::STEP_W-1:0] STEP_LAST =
		gtm_pkg::STEP_W'(gtm_pkg::MAG_W);

	gtm_pkg::ctl_state_t state_q, state_d;
	logic [gtm_pkg::IDX_W-1:0]  ia_q, ia_d, ib_q, ib_d;
	logic                       sq_q, sq_d;
	logic [gtm_pkg::STEP_W-1:0] step_q, step_d;
	logic                       last_q, last_d;
	logic                       out_valid_q, out_valid_d;
	logic                       ia_last, ib_last;

	assign ia_last   = (ia_q == LIMB_LAST);
	assign ib_last   = (ib_q == LIMB_LAST);
	assign out_valid = out_valid_q;

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gtm_pkg::ST_IDLE;
			ia_q        <= '0;
			ib_q        <= '0;
			sq_q        <= 1'b0;
			step_q      <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ia_q        <= ia_d;
			ib_q        <= ib_d;
			sq_q        <= sq_d;
			step_q      <= step_d;
			last_q      <= last_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d     = state_q;
		ia_d        = ia_q;
		ib_d        = ib_q;
		sq_d        = sq_q;
		step_d      = step_q;
		last_d      = last_q;
		out_valid_d = out_valid_q & ~out_ready;
		in_ready    = 1'b0;
		cmd.op      = gtm_pkg::DP_NOP;
		cmd.msel    = gtm_pkg::MS_COS;
		cmd.ia      = ia_q;
		cmd.ib      = ib_q;
		cmd.first   = 1'b0;

		case (state_q)
			gtm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = gtm_pkg::DP_LOAD;
					last_d  = last;
					ia_d    = '0;
					ib_d    = '0;
					state_d = gtm_pkg::ST_REC_MAC;
				end
			end
			// c * s1 for the recurrence and I, sn * s1 for Q, one limb of s1 per cycle
			gtm_pkg::ST_REC_MAC, gtm_pkg::ST_I_MAC, gtm_pkg::ST_Q_MAC: begin
				cmd.op    = gtm_pkg::DP_MAC;
				cmd.msel  = (state_q == gtm_pkg::ST_Q_MAC) ? gtm_pkg::MS_SIN : gtm_pkg::MS_COS;
				cmd.first = (ib_q == '0);
				ib_d      = ib_q + 1'b1;
				if (ib_last) begin
					ib_d = '0;
					case (state_q)
						gtm_pkg::ST_REC_MAC: state_d = gtm_pkg::ST_REC_DRAIN;
						gtm_pkg::ST_I_MAC:   state_d = gtm_pkg::ST_I_DRAIN;
						default:             state_d = gtm_pkg::ST_Q_DRAIN;
					endcase
				end
			end
			gtm_pkg::ST_REC_DRAIN: begin
				state_d = gtm_pkg::ST_REC_DONE;
			end
			gtm_pkg::ST_REC_DONE: begin
				cmd.op  = gtm_pkg::DP_REC;
				state_d = last_q ? gtm_pkg::ST_I_MAC : gtm_pkg::ST_IDLE;
			end
			gtm_pkg::ST_I_DRAIN: begin
				state_d = gtm_pkg::ST_I_DONE;
			end
			gtm_pkg::ST_I_DONE: begin
				cmd.op  = gtm_pkg::DP_IVAL;
				state_d = gtm_pkg::ST_Q_MAC;
			end
			gtm_pkg::ST_Q_DRAIN: begin
				state_d = gtm_pkg::ST_Q_DONE;
			end
			gtm_pkg::ST_Q_DONE: begin
				cmd.op  = gtm_pkg::DP_QVAL;
				ia_d    = '0;
				ib_d    = '0;
				sq_d    = 1'b0;
				state_d = gtm_pkg::ST_SQ_MAC;
			end
			// I^2 then Q^2, all limb pairs; skipped when a term is out of range
			gtm_pkg::ST_SQ_MAC: begin
				if (sts.big) begin
					state_d = gtm_pkg::ST_OUT;
				end else begin
					cmd.op    = gtm_pkg::DP_MAC;
					cmd.msel  = sq_q ? gtm_pkg::MS_SQ_Q : gtm_pkg::MS_SQ_I;
					cmd.first = ~sq_q & (ia_q == '0) & (ib_q == '0);
					ib_d      = ib_q + 1'b1;
					if (ib_last) begin
						ib_d = '0;
						ia_d = ia_q + 1'b1;
						if (ia_last) begin
							ia_d = '0;
							sq_d = 1'b1;
							if (sq_q) begin
								state_d = gtm_pkg::ST_SQ_DRAIN;
							end
						end
					end
				end
			end
			gtm_pkg::ST_SQ_DRAIN: begin
				step_d  = '0;
				state_d = gtm_pkg::ST_SQRT;
			end
			gtm_pkg::ST_SQRT: begin
				cmd.op = gtm_pkg::DP_SQRT;
				step_d = step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					state_d = gtm_pkg::ST_OUT;
				end
			end
			gtm_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op      = gtm_pkg::DP_OUT;
					out_valid_d = 1'b1;
					state_d     = gtm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gtm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/gtm_datapath.sv -----
module gtm_datapath #(
	parameter int SAMPLE_WIDTH   = gtm_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = gtm_pkg::COEF_FRAC_BITS_DEF,
	parameter int STATE_WIDTH    = gtm_pkg::STATE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gtm_pkg::dp_cmd_t                  cmd,
	output gtm_pkg::dp_sts_t                  sts,
	input  logic signed [SAMPLE_WIDTH-1:0]    sample,
	input  logic                              cfg_we,
	input  logic [gtm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gtm_pkg::COEF_W-1:0]        cfg_data,
	output logic [gtm_pkg::MAG_W-1:0]         magnitude,
	output logic                              saturated
);

	localparam int COEF_W = gtm_pkg::COEF_W;
	localparam int MAG_W  = gtm_pkg::MAG_W;
	localparam int LIMB_W = gtm_pkg::LIMB_W;
	localparam int WIDE_W = gtm_pkg::WIDE_W;
	localparam int IDX_W  = gtm_pkg::IDX_W;
	localparam int POS_W  = gtm_pkg::POS_W;
	localparam int MUL_W  = gtm_pkg::MUL_W;
	localparam int PROD_W = gtm_pkg::PROD_W;
	localparam int ACC_W  = gtm_pkg::ACC_W;
	localparam int REM_W  = gtm_pkg::REM_W;
	localparam int SUM_W  = ACC_W + 1;

	// Pick one 24-bit limb of a 72-bit operand
	function automatic logic [LIMB_W-1:0] limb_of(input logic [WIDE_W-1:0] v,
		input logic [IDX_W-1:0] idx);
		logic [LIMB_W-1:0] r;
		case (idx)
			2'd0:    r = v[LIMB_W-1:0];
			2'd1:    r = v[2*LIMB_W-1:LIMB_W];
			2'd2:    r = v[3*LIMB_W-1:2*LIMB_W];
			default: r = '0;
		endcase
		return r;
	endfunction

	// Place a partial product at its limb position
	function automatic logic signed [ACC_W-1:0] limb_shift(input logic signed [ACC_W-1:0] v,
		input logic [POS_W-1:0] pos);
		logic signed [ACC_W-1:0] r;
		case (pos)
			3'd0:    r = v;
			3'd1:    r = v <<< LIMB_W;
			3'd2:    r = v <<< (2 * LIMB_W);
			3'd3:    r = v <<< (3 * LIMB_W);
			3'd4:    r = v <<< (4 * LIMB_W);
			default: r = '0;
		endcase
		return r;
	endfunction

	logic signed [COEF_W-1:0]       cos_q, sin_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [STATE_WIDTH-1:0]  s1_q, s2_q;
	logic                           ovf_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic [MAG_W-1:0]               ai_q, aq_q;
	logic                           big_q;
	logic [MAG_W:0]                 root_q;
	logic [REM_W-1:0]               rem_q;
	logic [MAG_W-1:0]               mag_q;
	logic                           sat_q;

	logic signed [PROD_W-1:0]       prod_s1;
	logic [POS_W-1:0]               pos_s1;
	logic                           first_s1;
	logic                           mac_s1;

	logic [WIDE_W-1:0]              s1_wide, ai_wide, aq_wide;
	logic [LIMB_W-1:0]              s1_limb, sq_limb_a, sq_limb_b;
	logic                           s1_top;
	logic signed [MUL_W-1:0]        op_a, op_b;
	logic signed [ACC_W-1:0]        acc_base, acc_mac, acc_rec, acc_frac;
	logic signed [SUM_W-1:0]        rec_sum, iq_sub, iq_val;
	logic [SUM_W-1:0]               iq_abs;
	logic                           rec_fits, iq_big;
	logic [STATE_WIDTH-1:0]         rec_sat, s_next;
	logic [REM_W-1:0]               rem_n, trial;
	logic                           rem_ge;
	logic                           out_clamp;

	assign sts.big   = big_q;
	assign magnitude = mag_q;
	assign saturated = sat_q;

	// Multiplier operand select
	assign s1_wide = WIDE_W'(s1_q);
	assign ai_wide = WIDE_W'(ai_q);
	assign aq_wide = WIDE_W'(aq_q);
	assign s1_limb = limb_of(s1_wide, cmd.ib);
	assign s1_top  = (cmd.ib == IDX_W'(gtm_pkg::NUM_LIMBS - 1));

	always_comb begin
		sq_limb_a = '0;
		sq_limb_b = '0;
		case (cmd.msel)
			gtm_pkg::MS_COS: begin
				op_a = MUL_W'(cos_q);
				op_b = {s1_top & s1_limb[LIMB_W-1], s1_limb};
			end
			gtm_pkg::MS_SIN: begin
				op_a = MUL_W'(sin_q);
				op_b = {s1_top & s1_limb[LIMB_W-1], s1_limb};
			end
			gtm_pkg::MS_SQ_I: begin
				sq_limb_a = limb_of(ai_wide, cmd.ia);
				sq_limb_b = limb_of(ai_wide, cmd.ib);
				op_a      = {1'b0, sq_limb_a};
				op_b      = {1'b0, sq_limb_b};
			end
			gtm_pkg::MS_SQ_Q: begin
				sq_limb_a = limb_of(aq_wide, cmd.ia);
				sq_limb_b = limb_of(aq_wide, cmd.ib);
				op_a      = {1'b0, sq_limb_a};
				op_b      = {1'b0, sq_limb_b};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Accumulate the registered partial product
	assign acc_base = first_s1 ? '0 : acc_q;
	assign acc_mac  = acc_base + limb_shift(ACC_W'(prod_s1), pos_s1);

	// Recurrence: s = x + floor(2c*s1) - s2, saturated to the state width
	assign acc_rec  = acc_q >>> (COEF_FRAC_BITS - 1);
	assign rec_sum  = SUM_W'(acc_rec) + SUM_W'(x_q) - SUM_W'(s2_q);
	assign rec_fits = (&rec_sum[SUM_W-1:STATE_WIDTH-1]) | ~(|rec_sum[SUM_W-1:STATE_WIDTH-1]);
	assign rec_sat  = rec_sum[SUM_W-1] ? {1'b1, {(STATE_WIDTH-1){1'b0}}}
	                                   : {1'b0, {(STATE_WIDTH-1){1'b1}}};
	assign s_next   = rec_fits ? rec_sum[STATE_WIDTH-1:0] : rec_sat;

	// I = floor(c*s1) - s2, Q = floor(sn*s1), then absolute value and range check
	assign acc_frac = acc_q >>> COEF_FRAC_BITS;
	assign iq_sub   = (cmd.op == gtm_pkg::DP_IVAL) ? SUM_W'(s2_q) : SUM_W'(0);
	assign iq_val   = SUM_W'(acc_frac) - iq_sub;
	assign iq_abs   = iq_val[SUM_W-1] ? SUM_W'(-iq_val) : iq_val;
	assign iq_big   = |iq_abs[SUM_W-1:MAG_W];

	// Square root, two radicand bits per step
	assign rem_n  = {rem_q[REM_W-3:0], acc_q[ACC_W-1:ACC_W-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign rem_ge = (rem_n >= trial);

	assign out_clamp = big_q | root_q[MAG_W];

	// Coefficients, recurrence state and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q  <= gtm_pkg::COS_RESET;
			sin_q  <= gtm_pkg::SIN_RESET;
			s1_q   <= '0;
			s2_q   <= '0;
			ovf_q  <= 1'b0;
			mac_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gtm_pkg::CFG_COS: cos_q <= cfg_data;
					gtm_pkg::CFG_SIN: sin_q <= cfg_data;
					default: ;
				endcase
			end
			mac_s1 <= (cmd.op == gtm_pkg::DP_MAC);
			case (cmd.op)
				gtm_pkg::DP_REC: begin
					s2_q  <= s1_q;
					s1_q  <= s_next;
					ovf_q <= ovf_q | ~rec_fits;
				end
				gtm_pkg::DP_OUT: begin
					s1_q  <= '0;
					s2_q  <= '0;
					ovf_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		prod_s1  <= op_a * op_b;
		pos_s1   <= POS_W'(cmd.ia) + POS_W'(cmd.ib);
		first_s1 <= cmd.first;
		if (mac_s1) begin
			acc_q <= acc_mac;
		end else if (cmd.op == gtm_pkg::DP_SQRT) begin
			acc_q <= acc_q <<< 2;
		end
		case (cmd.op)
			gtm_pkg::DP_LOAD: begin
				x_q <= sample;
			end
			gtm_pkg::DP_IVAL: begin
				ai_q   <= iq_abs[MAG_W-1:0];
				big_q  <= iq_big;
				root_q <= '0;
				rem_q  <= '0;
			end
			gtm_pkg::DP_QVAL: begin
				aq_q  <= iq_abs[MAG_W-1:0];
				big_q <= big_q | iq_big;
			end
			gtm_pkg::DP_SQRT: begin
				rem_q  <= rem_ge ? (rem_n - trial) : rem_n;
				root_q <= {root_q[MAG_W-1:0], rem_ge};
			end
			gtm_pkg::DP_OUT: begin
				mag_q <= out_clamp ? '1 : root_q[MAG_W-1:0];
				sat_q <= ovf_q | out_clamp;
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/goertzel_tone_magnitude.sv -----
// Channel   Handshake              Payload
// --------  ---------------------  -----------------------------------------
// in        in_valid / in_ready    sample[SAMPLE_WIDTH], last
// out       out_valid / out_ready  magnitude[50], saturated
// cfg       cfg_valid / cfg_ready  cfg_index[2] (0 cos, 1 sin), cfg_data[18]
//
// A sample takes three 25x25 limb products of coef*state through the
// single shared multiplier, one accumulate step, one state update.
// A last sample takes the recurrence, I and Q (3 products each),
// 18 limb products for I^2+Q^2 and 51 square-root steps, one bit each.
// Out-of-range I or Q skips the squares and root.
// Reset clears the state and sets cos to 1.0, sin to 0; cfg_ready is always high.
// A waiting result holds only the final output step; samples keep flowing.
module goertzel_tone_magnitude #(
	parameter int SAMPLE_WIDTH   = gtm_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = gtm_pkg::COEF_FRAC_BITS_DEF,
	parameter int STATE_WIDTH    = gtm_pkg::STATE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gtm_pkg::MAG_W-1:0]      magnitude,
	output logic                           saturated,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gtm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gtm_pkg::COEF_W-1:0]     cfg_data
);

	gtm_pkg::dp_cmd_t cmd;
	gtm_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	// Sequencer
	gtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic and state
	gtm_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.STATE_WIDTH    (STATE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.sample    (sample),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.magnitude (magnitude),
		.saturated (saturated)
	);

	// An accepted item keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted back to back");

	// The output step always presents a result
	a_out_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == gtm_pkg::DP_OUT) |=> out_valid)
		else $error("result not presented after output step");

	// A result appears only from the output step
	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.op == gtm_pkg::DP_OUT))
		else $error("result appeared without output step");

endmodule
